>>> rtl/sdd_pkg.sv
// ----------------------------------------------------------------------------
// sdd_pkg
// Shared types and constants for the single-key debounce detector.
// ----------------------------------------------------------------------------
package sdd_pkg;

  localparam int KEY_BITS = 10;
  localparam int KEYS     = 10;
  localparam int IDX_W    = 4;
  localparam int THR_W    = 4;

  // keys at or above KEYS are never looked at
  localparam logic [KEY_BITS-1:0] KEY_MASK =
    (KEYS >= KEY_BITS) ? {KEY_BITS{1'b1}} : KEY_BITS'((64'd1 << KEYS) - 64'd1);

  localparam logic [IDX_W-1:0] NO_KEY       = 4'd15;
  localparam logic [THR_W-1:0] THRESH_RESET = 4'd3;

  typedef enum logic [2:0] {
    MODE_RELEASED   = 3'b001,
    MODE_DEBOUNCING = 3'b010,
    MODE_PRESSED    = 3'b100
  } mode_t;

  typedef struct packed {
    logic             none;
    logic             single;
    logic [IDX_W-1:0] idx;
  } key_class_t;

  typedef struct packed {
    logic             down;
    logic [IDX_W-1:0] index;
  } key_result_t;

endpackage

>>> rtl/sdd_classify.sv
// ----------------------------------------------------------------------------
// sdd_classify
// Inverts the active-low key pins and sorts a poll into no key, one key
// (with its index) or several keys.
// ----------------------------------------------------------------------------
module sdd_classify (
  input  logic [sdd_pkg::KEY_BITS-1:0] key_levels,
  output sdd_pkg::key_class_t          cls
);
  import sdd_pkg::*;

  logic [KEY_BITS-1:0] pressed;
  logic [IDX_W-1:0]    idx_or;

  assign pressed = ~key_levels & KEY_MASK;

  // index is only meaningful for a single key, so an or over set bits is enough
  always_comb begin
    idx_or = '0;
    for (int i = 0; i < KEY_BITS; i++) begin
      if (pressed[i]) begin
        idx_or = idx_or | IDX_W'(i);
      end
    end
  end

  assign cls.none   = (pressed == '0);
  assign cls.single = $onehot(pressed);
  assign cls.idx    = idx_or;

endmodule

>>> rtl/sdd_fsm.sv
// ----------------------------------------------------------------------------
// sdd_fsm
// Debounce state machine and threshold register. Steps once per request
// moved into the result register.
// ----------------------------------------------------------------------------
module sdd_fsm (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [sdd_pkg::THR_W-1:0]  cfg_wr_data,
  input  logic                       advance,
  input  sdd_pkg::key_class_t        cls,
  output sdd_pkg::key_result_t       result
);
  import sdd_pkg::*;

  mode_t            mode, mode_next;
  logic [IDX_W-1:0] candidate_key, candidate_key_next;
  logic [THR_W-1:0] match_count, match_count_next;
  logic [THR_W-1:0] threshold;
  logic [THR_W:0]   count_inc;

  // compare at one extra bit so a threshold of fifteen still fires
  assign count_inc = {1'b0, match_count} + {{THR_W{1'b0}}, 1'b1};

  always_comb begin
    mode_next          = mode;
    candidate_key_next = candidate_key;
    match_count_next   = match_count;
    result             = '0;
    case (mode)
      MODE_RELEASED: begin
        if (cls.single) begin
          mode_next          = MODE_DEBOUNCING;
          candidate_key_next = cls.idx;
          match_count_next   = THR_W'(1);
        end
      end
      MODE_DEBOUNCING: begin
        if (cls.none) begin
          mode_next          = MODE_RELEASED;
          candidate_key_next = NO_KEY;
          match_count_next   = '0;
        end else if (!cls.single) begin
          mode_next          = MODE_PRESSED;
          candidate_key_next = NO_KEY;
          match_count_next   = '0;
        end else if (cls.idx == candidate_key) begin
          if (count_inc > {1'b0, threshold}) begin
            mode_next          = MODE_PRESSED;
            candidate_key_next = NO_KEY;
            match_count_next   = '0;
            result.down        = 1'b1;
            result.index       = cls.idx;
          end else begin
            match_count_next = count_inc[THR_W-1:0];
          end
        end else begin
          // another key took over: wait for full release, no pulse
          mode_next          = MODE_PRESSED;
          candidate_key_next = cls.idx;
          match_count_next   = THR_W'(1);
        end
      end
      default: begin
        if (cls.none) begin
          mode_next = MODE_RELEASED;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_PRESSED;
      candidate_key <= NO_KEY;
      match_count   <= '0;
    end else if (advance) begin
      mode          <= mode_next;
      candidate_key <= candidate_key_next;
      match_count   <= match_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESH_RESET;
    end else if (cfg_wr_en) begin
      threshold <= cfg_wr_data;
    end
  end

  a_debounce_count_set: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_DEBOUNCING |-> match_count != '0)
    else $error("debouncing with zero match count");

  a_down_goes_pressed: assert property (@(posedge clk) disable iff (rst)
    advance && result.down |=> mode == MODE_PRESSED && match_count == '0)
    else $error("key-down did not move to pressed");

  a_down_only_debouncing: assert property (@(posedge clk) disable iff (rst)
    result.down |-> mode == MODE_DEBOUNCING && cls.single)
    else $error("key-down outside debouncing");

endmodule

>>> rtl/single_key_debounce_detector.sv
// ----------------------------------------------------------------------------
// single_key_debounce_detector
// Takes one poll of the active-low key pins per request and returns one
// result per poll: a key-down pulse with the key index once the same single
// key has been seen in more consecutive polls than the debounce threshold,
// after which the block waits for every key to be released. A new poll is
// taken every cycle unless in_ready is held low by a stalled result register;
// each poll passes through an input register and then a result register, with
// the classify and state update between them. The threshold resets to 3 and
// is written through cfg_wr_en and cfg_wr_data; the user must write it only
// while the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module single_key_debounce_detector (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [sdd_pkg::THR_W-1:0]     cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sdd_pkg::KEY_BITS-1:0]  key_levels,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          key_down,
  output logic [sdd_pkg::IDX_W-1:0]     key_index
);
  import sdd_pkg::*;

  logic                s1_valid;
  logic [KEY_BITS-1:0] s1_levels;
  logic                advance;
  key_class_t          cls;
  key_result_t         result;

  // the result register frees up in the same cycle it is read out
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_levels <= key_levels;
    end
  end

  sdd_classify u_classify (
    .key_levels (s1_levels),
    .cls        (cls)
  );

  sdd_fsm u_fsm (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .advance     (advance),
    .cls         (cls),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      key_down  <= result.down;
      key_index <= result.index;
    end
  end

  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && key_down |-> int'(key_index) < KEYS)
    else $error("key index out of range");

  a_index_zero_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && !key_down |-> key_index == '0)
    else $error("key index set without key-down");

  a_no_back_to_back_down: assert property (@(posedge clk) disable iff (rst)
    advance && result.down |=> !(advance && result.down))
    else $error("two key-down pulses in a row");

endmodule
